>>> rtl/sbc_pkg.sv
// ----------------------------------------------------------------------------
// sbc_pkg: shared definitions for the sprite blitter
// Matrix and image store sizes, command and status codes, register indexes
// and the clipping summary that the clip unit hands to the sequencer.
// ----------------------------------------------------------------------------
package sbc_pkg;

  // Matrix and image store geometry. IMAGE_BYTES must be a power of two, so
  // that image addresses wrap by dropping high bits.
  localparam int MATRIX_WIDTH  = 32;
  localparam int MATRIX_HEIGHT = 16;
  localparam int IMAGE_BYTES   = 1024;

  localparam int COL_W  = $clog2(MATRIX_WIDTH);
  localparam int ROW_W  = $clog2(MATRIX_HEIGHT);
  localparam int IMG_AW = $clog2(IMAGE_BYTES);

  // Signed width used for the clipping arithmetic on 11-bit positions.
  localparam int CLIP_W = 12;

  // Dots per packed byte, the mask for the dot within a byte and its MSB.
  localparam int          DOTS_PER_BYTE = 8;
  localparam logic [2:0]  DOT_MASK      = 3'h7;
  localparam logic [2:0]  DOT_MSB       = 3'd7;

  // Command codes carried in the mode field.
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_RENDER = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  localparam logic [1:0] MODE_WRITE  = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_PACKED_WIDTH = 2'd1;
  localparam logic [1:0] ST_OFF_MATRIX   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_SPRITE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SPRITE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DOT_FORMAT    = 2'd2;

  // Dot format codes.
  localparam logic FMT_BYTE   = 1'b0;
  localparam logic FMT_PACKED = 1'b1;

  // Result of clipping one render request against the matrix.
  typedef struct packed {
    logic [1:0]       status;     // code to report; nonzero means no drawing
    logic             empty;      // degenerate rectangle, nothing to visit
    logic [COL_W-1:0] col_first;
    logic [COL_W-1:0] col_last;
    logic [ROW_W-1:0] row_first;
    logic [ROW_W-1:0] row_last;
    logic [7:0]       dc_first;   // sprite column of the first visited dot
    logic [7:0]       dr_first;   // sprite row of the first visited dot
  } clip_t;

endpackage

>>> rtl/sprite_blit_clip.sv
// ----------------------------------------------------------------------------
// sprite_blit_clip: sprite blitter with rectangle clipping
// Draws a sprite from an image store into a one-bit LED matrix frame store.
// ----------------------------------------------------------------------------
// Usage. A command word is taken at a rising edge where start is high and
// busy is low. Its mode selects one of four operations: load one image byte,
// render the sprite at a signed position, read a frame row, or write a frame
// row. Every command yields exactly one result word, shown on status and
// row_out for a single cycle while done is high; the receiver cannot stall.
// The user must set sprite width, height and dot format only while the block
// is idle, via the write port (cfg_write, cfg_index, cfg_data); not enforced.
//
// Timing. Load, read and write commands finish at once: done is high in the
// cycle right after the accept edge and busy never rises. A render that
// fails the packed width check, misses the matrix or clips to nothing also
// answers in that cycle. A render that draws is clipped at the accept edge,
// forms the starting image address in a prepare state (one 8 by 8
// multiply), visits one clipped dot per cycle through the single read port
// of the image memory, then retires the last dot in a drain state. Busy
// stays high through the prepare, scan and drain states, and done is high in
// the cycle after the drain state.
//
// Reset clears the frame store, the configuration (8 by 8, one byte per dot)
// and the sequencer. The image store is not cleared.
// ----------------------------------------------------------------------------
module sprite_blit_clip (
  input  logic               clk,
  input  logic               rst,
  // Command channel
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode,
  input  logic [9:0]         index,
  input  logic [7:0]         image_byte,
  input  logic [31:0]        row_in,
  input  logic signed [10:0] sprite_x,
  input  logic signed [10:0] sprite_y,
  // Result channel
  output logic               done,
  output logic [1:0]         status,
  output logic [31:0]        row_out,
  // Configuration write port
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);
  import sbc_pkg::*;

  // Sequencer states.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PREP  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_DRAIN = 2'd3;

  logic [1:0] state;

  // Configuration registers.
  logic [7:0] sprite_width;
  logic [7:0] sprite_height;
  logic       dot_format;

  // Storage. The image store is a plain memory with a write port and a
  // registered read port; the frame store is small enough to live in flip-flops.
  logic [7:0]              image_mem [IMAGE_BYTES];
  logic [7:0]              img_rdata;
  logic [MATRIX_WIDTH-1:0] frame [MATRIX_HEIGHT];

  // Scan state.
  logic [COL_W-1:0]  col, col_first, col_last;
  logic [ROW_W-1:0]  row, row_last;
  logic [7:0]        dc, dc_first, dr_first;
  logic [7:0]        stride;
  logic [IMG_AW-1:0] base;

  // Dot retire stage, registered alongside the image read data.
  logic              p_valid;
  logic [COL_W-1:0]  p_col;
  logic [ROW_W-1:0]  p_row;
  logic [2:0]        p_bit;

  clip_t             clip;
  logic              accept;
  logic              row_ok;
  logic [7:0]        dc_byte;
  logic [IMG_AW-1:0] rd_addr;
  logic [15:0]       prod;
  logic              lit;

  sbc_clip u_clip (
    .fmt    (dot_format),
    .width  (sprite_width),
    .height (sprite_height),
    .x      (sprite_x),
    .y      (sprite_y),
    .clip   (clip)
  );

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign row_ok = (index < 10'(MATRIX_HEIGHT));

  // In packed format the byte column is the dot column divided by eight.
  assign dc_byte = (dot_format == FMT_PACKED) ? 8'(dc / DOTS_PER_BYTE) : dc;
  assign rd_addr = base + IMG_AW'(dc_byte);
  assign prod    = 16'(stride) * 16'(dr_first);

  assign lit = (dot_format == FMT_PACKED) ? img_rdata[p_bit] : (img_rdata != 8'd0);

  // Configuration writes. An index past the register list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      sprite_width  <= 8'd8;
      sprite_height <= 8'd8;
      dot_format    <= FMT_BYTE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SPRITE_WIDTH:  sprite_width  <= cfg_data;
        REG_SPRITE_HEIGHT: sprite_height <= cfg_data;
        REG_DOT_FORMAT:    dot_format    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Image memory: loads come from the command port, reads from the scan.
  always_ff @(posedge clk) begin
    if (accept && mode == MODE_LOAD) begin
      image_mem[IMG_AW'(index)] <= image_byte;
    end
    img_rdata <= image_mem[rd_addr];
  end

  // Frame store: whole-row writes from the command port, single dot sets
  // from the retire stage. Rendering only ever sets dots.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame <= '{default: '0};
    end else if (accept && mode == MODE_WRITE && row_ok) begin
      frame[ROW_W'(index)] <= MATRIX_WIDTH'(row_in);
    end else if (p_valid && lit) begin
      frame[p_row][p_col] <= 1'b1;
    end
  end

  // Retire stage bookkeeping for the dot whose image byte is being read.
  always_ff @(posedge clk) begin
    p_col <= col;
    p_row <= row;
    p_bit <= DOT_MSB - (dc[2:0] & DOT_MASK);
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      p_valid <= 1'b0;
      status  <= ST_OK;
      row_out <= '0;
    end else begin
      done    <= 1'b0;
      p_valid <= (state == S_SCAN);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            status  <= ST_OK;
            row_out <= '0;
            unique case (mode)
              MODE_RENDER: begin
                col_first <= clip.col_first;
                col_last  <= clip.col_last;
                row       <= clip.row_first;
                row_last  <= clip.row_last;
                dc_first  <= clip.dc_first;
                dr_first  <= clip.dr_first;
                stride    <= (dot_format == FMT_PACKED) ?
                             8'(sprite_width / DOTS_PER_BYTE) : sprite_width;
                if (clip.status != ST_OK || clip.empty) begin
                  // Rejected or clipped to nothing: answer right away.
                  status <= clip.status;
                  done   <= 1'b1;
                end else begin
                  state <= S_PREP;
                end
              end
              MODE_READ: begin
                if (row_ok) begin
                  row_out <= 32'(frame[ROW_W'(index)]);
                end
                done <= 1'b1;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_PREP: begin
          // Image address of the first visited row.
          base  <= IMG_AW'(prod);
          col   <= col_first;
          dc    <= dc_first;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (col == col_last) begin
            col  <= col_first;
            dc   <= dc_first;
            base <= base + IMG_AW'(stride);
            if (row == row_last) begin
              state <= S_DRAIN;
            end else begin
              row <= row + ROW_W'(1);
            end
          end else begin
            col <= col + COL_W'(1);
            dc  <= dc + 8'd1;
          end
        end
        S_DRAIN: begin
          // The last dot retires at this edge.
          status <= ST_OK;
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/sbc_clip.sv
// ----------------------------------------------------------------------------
// sbc_clip: sprite rectangle clipping
// Checks a render request and clips the sprite rectangle to the matrix,
// giving the visited row and column range and the starting sprite offsets.
// ----------------------------------------------------------------------------
module sbc_clip (
  input  logic                 fmt,
  input  logic [7:0]           width,
  input  logic [7:0]           height,
  input  logic signed [10:0]   x,
  input  logic signed [10:0]   y,
  output sbc_pkg::clip_t       clip
);
  import sbc_pkg::*;

  localparam logic signed [CLIP_W-1:0] XMAX = CLIP_W'(MATRIX_WIDTH - 1);
  localparam logic signed [CLIP_W-1:0] YMAX = CLIP_W'(MATRIX_HEIGHT - 1);
  localparam logic signed [CLIP_W-1:0] ONE  = CLIP_W'(1);
  localparam logic signed [CLIP_W-1:0] ZERO = '0;

  logic signed [CLIP_W-1:0] xs, ys, ws, hs, r1, b1, cs, ce, rs, re, dc, dr;
  logic                     off_matrix;

  always_comb begin
    xs = {{(CLIP_W-11){x[10]}}, x};
    ys = {{(CLIP_W-11){y[10]}}, y};
    ws = {{(CLIP_W-8){1'b0}}, width};
    hs = {{(CLIP_W-8){1'b0}}, height};
    r1 = xs + ws - ONE;
    b1 = ys + hs - ONE;

    off_matrix = !(r1 >= ZERO && xs <= XMAX && b1 >= ZERO && ys <= YMAX);

    cs = (xs < ZERO) ? ZERO : xs;
    ce = (r1 > XMAX) ? XMAX : r1;
    rs = (ys < ZERO) ? ZERO : ys;
    re = (b1 > YMAX) ? YMAX : b1;
    dc = cs - xs;
    dr = rs - ys;

    if (fmt == FMT_PACKED && (width[2:0] & DOT_MASK) != 3'd0) begin
      clip.status = ST_PACKED_WIDTH;
    end else if (off_matrix) begin
      clip.status = ST_OFF_MATRIX;
    end else begin
      clip.status = ST_OK;
    end
    clip.empty     = (ce < cs) || (re < rs);
    clip.col_first = COL_W'(cs);
    clip.col_last  = COL_W'(ce);
    clip.row_first = ROW_W'(rs);
    clip.row_last  = ROW_W'(re);
    clip.dc_first  = 8'(dc);
    clip.dr_first  = 8'(dr);
  end

endmodule
